// ----- src/psu_pkg.sv -----
// shared types, constants and helpers for the particle update pipeline
`default_nettype none
package psu_pkg;

   localparam int unsigned NumCsr = 8;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned QuoWidth = 16;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_START_COLOR = 3'd0,
      CSR_END_COLOR   = 3'd1,
      CSR_START_ALPHA = 3'd2,
      CSR_END_ALPHA   = 3'd3,
      CSR_EFFECT_MODE = 3'd4,
      CSR_SHRINK_END  = 3'd5,
      CSR_GRAVITY_X   = 3'd6,
      CSR_GRAVITY_Y   = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic        alive_in;
      logic [31:0] age_in;
      logic [31:0] lifetime;
      logic signed [31:0] vel_x_in;
      logic signed [31:0] vel_y_in;
      logic signed [31:0] pos_x_in;
      logic signed [31:0] pos_y_in;
      logic signed [31:0] angle_in;
      logic signed [31:0] spin_rate;
      logic [31:0] base_size;
      logic [31:0] time_step;
   } req_type;

   typedef struct packed {
      logic        alive_out;
      logic [31:0] age_out;
      logic signed [31:0] vel_x_out;
      logic signed [31:0] vel_y_out;
      logic signed [31:0] pos_x_out;
      logic signed [31:0] pos_y_out;
      logic signed [31:0] angle_out;
      logic [31:0] color_out;
      logic [16:0] alpha_out;
      logic [31:0] size_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0] start_color;
      logic [31:0] end_color;
      logic [16:0] start_alpha;
      logic [16:0] end_alpha;
      logic [1:0]  effect_mode;
      logic [23:0] shrink_end_scale;
      logic signed [31:0] gravity_x;
      logic signed [31:0] gravity_y;
   } cfg_type;

   // per-stage control travelling beside the data
   typedef struct packed {
      logic valid;
      logic live;
      logic died;
   } stage_ctl_type;

   // floor(p / 65536) of a signed 64 bit product, added and saturated
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                 input logic signed [63:0] p);
      logic signed [48:0] s;
      s = 49'(x) + 49'($signed(p[63:16]));
      if (s > 49'sd2147483647) return 32'sh7fffffff;
      if (s < -49'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   // a + (b-a)*t/65536 floored, unsigned ends up to 24 bits
   function automatic logic [24:0] blend(input logic [24:0] a, input logic [24:0] b,
                                         input logic [15:0] t);
      logic signed [43:0] s;
      s = $signed({1'b0, a, 16'd0}) + ($signed({1'b0, b}) - $signed({1'b0, a}))
          * $signed({1'b0, t});
      return s[40:16];
   endfunction

endpackage
`default_nettype wire

// ----- src/psu_div.sv -----
// pipelined restoring divider giving t = floor(age * 65536 / lifetime), one bit per stage
`default_nettype none
module psu_div #(
   parameter int unsigned Bits = psu_pkg::QuoWidth
) (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [31:0] num,
   input  wire logic [31:0] den,
   output logic [Bits-1:0]  quo
);
   // age < lifetime, so remainder always fits below den
   logic [32:0]     rem_ff [Bits];
   logic [31:0]     den_ff [Bits];
   logic [Bits-1:0] q_ff   [Bits];

   for (genvar i = 0; i < Bits; i++) begin : g_step
      logic [32:0]     rem_prev;
      logic [31:0]     den_prev;
      logic [Bits-1:0] q_prev;
      logic [33:0]     sh_in;
      logic [33:0]     diff_in;
      if (i == 0) begin : g_first
         assign rem_prev = {1'b0, num};
         assign den_prev = den;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign q_prev   = q_ff[i-1];
      end
      assign sh_in   = {rem_prev, 1'b0};
      assign diff_in = sh_in - {2'b0, den_prev};
      always_ff @(posedge clock) begin
         if (enable) begin
            den_ff[i] <= den_prev;
            if (!diff_in[33]) begin
               rem_ff[i] <= diff_in[32:0];
               q_ff[i]   <= {q_prev[Bits-2:0], 1'b1};
            end else begin
               rem_ff[i] <= sh_in[32:0];
               q_ff[i]   <= {q_prev[Bits-2:0], 1'b0};
            end
         end
      end
   end

   assign quo = q_ff[Bits-1];
endmodule
`default_nettype wire

// ----- src/psu_kin.sv -----
// kinematics: age, gravity, position and angle over pipeline stages
`default_nettype none
module psu_kin (
   input  wire logic            clock,
   input  wire logic            enable,
   input  wire psu_pkg::req_type req,
   input  wire psu_pkg::cfg_type cfg,
   output psu_pkg::rsp_type     kin,
   output logic                 live,
   output logic [31:0]          age
);
   // stage 1: age and products for gravity and spin
   psu_pkg::req_type r1_ff;
   logic [31:0] age1_ff;
   logic live1_ff;
   logic signed [63:0] gx1_ff, gy1_ff, sp1_ff;
   logic [32:0] age_sum;
   logic [31:0] age_sat;
   assign age_sum = {1'b0, req.age_in} + {1'b0, req.time_step};
   assign age_sat = age_sum[32] ? 32'hffffffff : age_sum[31:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         r1_ff    <= req;
         age1_ff  <= req.alive_in ? age_sat : req.age_in;
         live1_ff <= req.alive_in && (age_sat < req.lifetime);
         gx1_ff   <= cfg.gravity_x * $signed({1'b0, req.time_step});
         gy1_ff   <= cfg.gravity_y * $signed({1'b0, req.time_step});
         sp1_ff   <= req.spin_rate * $signed({1'b0, req.time_step});
      end
   end

   // stage 2: new velocity and angle
   psu_pkg::req_type r2_ff;
   logic [31:0] age2_ff;
   logic live2_ff;
   logic signed [31:0] vx2_ff, vy2_ff, an2_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         r2_ff    <= r1_ff;
         age2_ff  <= age1_ff;
         live2_ff <= live1_ff;
         vx2_ff   <= psu_pkg::sat_add(r1_ff.vel_x_in, gx1_ff);
         vy2_ff   <= psu_pkg::sat_add(r1_ff.vel_y_in, gy1_ff);
         an2_ff   <= psu_pkg::sat_add(r1_ff.angle_in, sp1_ff);
      end
   end

   // stage 3: position products
   psu_pkg::req_type r3_ff;
   logic [31:0] age3_ff;
   logic live3_ff;
   logic signed [31:0] vx3_ff, vy3_ff, an3_ff;
   logic signed [63:0] px3_ff, py3_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         r3_ff <= r2_ff; age3_ff <= age2_ff; live3_ff <= live2_ff;
         vx3_ff <= vx2_ff; vy3_ff <= vy2_ff; an3_ff <= an2_ff;
         px3_ff <= vx2_ff * $signed({1'b0, r2_ff.time_step});
         py3_ff <= vy2_ff * $signed({1'b0, r2_ff.time_step});
      end
   end

   // stage 4: positions
   always_ff @(posedge clock) begin
      if (enable) begin
         live <= live3_ff;
         age  <= age3_ff;
         kin.color_out <= '0;
         kin.alpha_out <= '0;
         kin.size_out  <= '0;
         kin.alive_out <= live3_ff;
         kin.age_out   <= age3_ff;
         if (live3_ff) begin
            kin.vel_x_out <= vx3_ff;
            kin.vel_y_out <= vy3_ff;
            kin.angle_out <= an3_ff;
            kin.pos_x_out <= psu_pkg::sat_add(r3_ff.pos_x_in, px3_ff);
            kin.pos_y_out <= psu_pkg::sat_add(r3_ff.pos_y_in, py3_ff);
         end else begin
            kin.vel_x_out <= r3_ff.vel_x_in;
            kin.vel_y_out <= r3_ff.vel_y_in;
            kin.angle_out <= r3_ff.angle_in;
            kin.pos_x_out <= r3_ff.pos_x_in;
            kin.pos_y_out <= r3_ff.pos_y_in;
         end
      end
   end
endmodule
`default_nettype wire

// ----- src/psu_fx.sv -----
// colour, alpha and size blends from the blend factor, two stages
`default_nettype none
module psu_fx (
   input  wire logic            clock,
   input  wire logic            enable,
   input  wire logic            live,
   input  wire logic [15:0]     t16,
   input  wire logic [31:0]     base_size,
   input  wire psu_pkg::cfg_type cfg,
   output logic [31:0]          color,
   output logic [16:0]          alpha,
   output logic [31:0]          size
);
   logic [31:0] col_ff;
   logic [16:0] al_ff;
   logic [24:0] f_ff;
   logic [31:0] base_ff;
   logic live_ff, shrink_ff;
   logic [31:0] col_in;
   logic [24:0] b_tmp;

   always_comb begin
      col_in = '0;
      for (int i = 0; i < 4; i++) begin
         b_tmp = psu_pkg::blend({17'd0, cfg.start_color[8*i +: 8]},
                                {17'd0, cfg.end_color[8*i +: 8]}, t16);
         col_in[8*i +: 8] = b_tmp[7:0];
      end
   end

   logic [24:0] al_tmp;
   assign al_tmp = psu_pkg::blend({8'd0, cfg.start_alpha}, {8'd0, cfg.end_alpha}, t16);

   always_ff @(posedge clock) begin
      if (enable) begin
         col_ff    <= col_in;
         al_ff     <= cfg.effect_mode[0] ? al_tmp[16:0] : cfg.start_alpha;
         f_ff      <= psu_pkg::blend(25'h10000, {1'b0, cfg.shrink_end_scale}, t16);
         base_ff   <= base_size;
         live_ff   <= live;
         shrink_ff <= cfg.effect_mode[1];
      end
   end

   logic [56:0] prod;
   assign prod = base_ff * f_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         color <= live_ff ? col_ff : '0;
         alpha <= live_ff ? al_ff : '0;
         if (!live_ff) size <= '0;
         else if (!shrink_ff) size <= base_ff;
         else size <= (|prod[56:48]) ? 32'hffffffff : prod[47:16];
      end
   end
endmodule
`default_nettype wire

// ----- src/particle_state_update_top.sv -----
// top level of the particle state update pipeline
//
// channel  direction  handshake          payload
// req_     in         req_valid/ready    psu_pkg::req_type
// rsp_     out        rsp_valid/ready    psu_pkg::rsp_type
// csr_     in         csr_valid/ready    csr_index, csr_data
//
// one request per cycle while the output is not stalled; the pipeline holds the 16 stage divider
// plus the kinematics stages ahead of it and the two blend stages after it
// reset clears the valid bits and loads the register defaults
// a stalled output freezes the whole pipeline; ready follows the last stage
`default_nettype none
module particle_state_update_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire psu_pkg::req_type    req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output psu_pkg::rsp_type         rsp_payload,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [psu_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [31:0]         csr_data
);
   localparam int unsigned QuoBits = psu_pkg::QuoWidth;
   localparam int unsigned KinDepth = 4;
   localparam int unsigned Depth = KinDepth + QuoBits + 2;

   psu_pkg::cfg_type cfg_ff;
   psu_pkg::csr_idx_type csr_sel;
   assign csr_sel   = psu_pkg::csr_idx_type'(csr_index);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{start_color: 32'hffffffff, end_color: 32'hffffffff,
                     start_alpha: 17'h10000, end_alpha: '0, effect_mode: '0,
                     shrink_end_scale: '0, gravity_x: '0, gravity_y: '0};
      end else if (csr_valid) begin
         unique case (csr_sel)
            psu_pkg::CSR_START_COLOR: cfg_ff.start_color      <= csr_data;
            psu_pkg::CSR_END_COLOR:   cfg_ff.end_color        <= csr_data;
            psu_pkg::CSR_START_ALPHA: cfg_ff.start_alpha      <= csr_data[16:0];
            psu_pkg::CSR_END_ALPHA:   cfg_ff.end_alpha        <= csr_data[16:0];
            psu_pkg::CSR_EFFECT_MODE: cfg_ff.effect_mode      <= csr_data[1:0];
            psu_pkg::CSR_SHRINK_END:  cfg_ff.shrink_end_scale <= csr_data[23:0];
            psu_pkg::CSR_GRAVITY_X:   cfg_ff.gravity_x        <= csr_data;
            psu_pkg::CSR_GRAVITY_Y:   cfg_ff.gravity_y        <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless the output holds an untaken result
   logic enable;
   logic [Depth-1:0] valid_ff;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = valid_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (enable) valid_ff <= {valid_ff[Depth-2:0], req_valid};
   end

   psu_pkg::rsp_type kin;
   logic kin_live;
   logic [31:0] kin_age;
   psu_kin u_kin (.clock, .enable, .req(req_payload), .cfg(cfg_ff), .kin,
                  .live(kin_live), .age(kin_age));

   // lifetime and base size ride alongside the kinematics stages
   logic [31:0] life_ff [KinDepth];
   logic [31:0] base_ff [KinDepth];
   always_ff @(posedge clock) begin
      if (enable) begin
         life_ff[0] <= req_payload.lifetime;
         base_ff[0] <= req_payload.base_size;
         for (int i = 1; i < KinDepth; i++) begin
            life_ff[i] <= life_ff[i-1];
            base_ff[i] <= base_ff[i-1];
         end
      end
   end

   // divider latency line for kinematics results and control
   psu_pkg::rsp_type dl_ff [QuoBits];
   logic             lv_ff [QuoBits];
   logic [31:0]      bs_ff [QuoBits];
   always_ff @(posedge clock) begin
      if (enable) begin
         dl_ff[0] <= kin; lv_ff[0] <= kin_live; bs_ff[0] <= base_ff[KinDepth-1];
         for (int i = 1; i < QuoBits; i++) begin
            dl_ff[i] <= dl_ff[i-1]; lv_ff[i] <= lv_ff[i-1]; bs_ff[i] <= bs_ff[i-1];
         end
      end
   end

   // a dead particle divides by one to keep the quotient harmless
   logic [QuoBits-1:0] t16;
   psu_div #(.Bits(QuoBits)) u_div (.clock, .enable,
      .num(kin_live ? kin_age : 32'd0),
      .den(kin_live ? life_ff[KinDepth-1] : 32'd1), .quo(t16));

   logic [31:0] color;
   logic [16:0] alpha;
   logic [31:0] size;
   psu_fx u_fx (.clock, .enable, .live(lv_ff[QuoBits-1]), .t16,
                .base_size(bs_ff[QuoBits-1]), .cfg(cfg_ff),
                .color, .alpha, .size);

   psu_pkg::rsp_type k1_ff, k2_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         k1_ff <= dl_ff[QuoBits-1];
         k2_ff <= k1_ff;
      end
   end

   always_comb begin
      rsp_payload = k2_ff;
      rsp_payload.color_out = color;
      rsp_payload.alpha_out = alpha;
      rsp_payload.size_out  = size;
   end
endmodule
`default_nettype wire

// ----- src/psu_checker.sv -----
// port-level checks for the particle update pipeline, bound to the top level
`default_nettype none
module psu_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire psu_pkg::rsp_type rsp_payload
);
   // a held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp changed while stalled");
   // request side blocks only while a result waits
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled without output stall");
   // a dead result carries no blends
   a_dead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.alive_out |-> rsp_payload.color_out == 32'd0 &&
      rsp_payload.size_out == 32'd0 && rsp_payload.alpha_out == 17'd0)
      else $error("dead particle with blend output");
   // nothing out right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp after reset");
endmodule

bind particle_state_update_top psu_checker u_psu_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_payload);
`default_nettype wire

// ----- sim/tb_particle_state_update_top.sv -----
// self-checking testbench for the particle state update pipeline
module tb_particle_state_update_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency = 22;
   localparam int CycleLimit = 400000;

   typedef struct {
      logic [31:0] start_color;
      logic [31:0] end_color;
      logic [16:0] start_alpha;
      logic [16:0] end_alpha;
      logic [1:0]  effect_mode;
      logic [23:0] shrink_end_scale;
      logic signed [31:0] gravity_x;
      logic signed [31:0] gravity_y;
   } shadow_regs_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   psu_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   psu_pkg::rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [psu_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // shadow copy of the block's registers, loaded with reset values
   shadow_regs_type regs = '{32'hffffffff, 32'hffffffff, 17'd65536, 17'd0, 2'd0, 24'd0, 0, 0};
   psu_pkg::rsp_type updated_records[$];    // predicted records waiting for the output
   int errors = 0;
   int cycles = 0;
   int burst_left = 8;             // requests left in the current burst
   int gap_max = 6;                // 0 keeps the sender offering with no gaps
   int hold_left = 0;              // long receiver hold-off, counted down below

   particle_state_update_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // predictor: one semi-implicit euler step in q16.16
   // ---------------------------------------------------------------

   // x + floor(rate*dt/65536), saturated to signed 32 bits
   function automatic longint step_q16(longint x, longint rate, longint dt);
      longint s;
      s = x + ((rate * dt) >>> 16);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
   endfunction

   // linear mix of a toward b by t/65536, rounded down
   function automatic longint mix_q16(longint a, longint b, longint t);
      return (a * 65536 + (b - a) * t) >>> 16;
   endfunction

   function automatic psu_pkg::rsp_type predict_update(psu_pkg::req_type r,
                                                       shadow_regs_type c);
      psu_pkg::rsp_type o;
      longint age, life, t, dt, vx, vy, f, sz, mixed;
      o = '0;
      o.age_out = r.age_in;
      o.vel_x_out = r.vel_x_in;
      o.vel_y_out = r.vel_y_in;
      o.pos_x_out = r.pos_x_in;
      o.pos_y_out = r.pos_y_in;
      o.angle_out = r.angle_in;
      // dead slot passes straight through
      if (!r.alive_in) return o;
      age = longint'(r.age_in) + longint'(r.time_step);
      if (age > 64'shffffffff) age = 64'shffffffff;
      o.age_out = age[31:0];
      life = longint'(r.lifetime);
      // dies this step, zero lifetime included
      if (age >= life) return o;
      o.alive_out = 1'b1;
      t = (age << 16) / life;
      dt = longint'(r.time_step);
      vx = step_q16(r.vel_x_in, c.gravity_x, dt);
      vy = step_q16(r.vel_y_in, c.gravity_y, dt);
      o.vel_x_out = vx[31:0];
      o.vel_y_out = vy[31:0];
      o.pos_x_out = 32'(step_q16(r.pos_x_in, vx, dt));
      o.pos_y_out = 32'(step_q16(r.pos_y_in, vy, dt));
      o.angle_out = 32'(step_q16(r.angle_in, r.spin_rate, dt));
      for (int b = 0; b < 4; b++) begin
         mixed = mix_q16(longint'(c.start_color[8*b +: 8]), longint'(c.end_color[8*b +: 8]), t);
         o.color_out[8*b +: 8] = mixed[7:0];
      end
      if (c.effect_mode[0]) begin
         mixed = mix_q16(longint'(c.start_alpha), longint'(c.end_alpha), t);
         o.alpha_out = mixed[16:0];
      end else begin
         o.alpha_out = c.start_alpha;
      end
      if (c.effect_mode[1]) begin
         f = mix_q16(65536, longint'(c.shrink_end_scale), t);
         sz = (longint'(r.base_size) * f) >>> 16;
         if (sz > 64'shffffffff) sz = 64'shffffffff;
         o.size_out = sz[31:0];
      end else begin
         o.size_out = r.base_size;
      end
      return o;
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // accepted requests are predicted at the edge they are taken,
   // accepted results are checked against the oldest prediction
   always @(posedge clock) begin
      psu_pkg::rsp_type want;
      cycles <= cycles + 1;
      if (!reset && req_valid && req_ready)
         updated_records.insert(updated_records.size(), predict_update(req_payload, regs));
      if (!reset && rsp_valid && rsp_ready) begin
         if (updated_records.size() == 0) begin
            report_mismatch("unexpected result", rsp_payload.age_out, 32'h0);
         end else begin
            want = updated_records.pop_front();
            compare_field("alive_out", 32'(rsp_payload.alive_out), 32'(want.alive_out));
            compare_field("age_out", rsp_payload.age_out, want.age_out);
            compare_field("vel_x_out", rsp_payload.vel_x_out, want.vel_x_out);
            compare_field("vel_y_out", rsp_payload.vel_y_out, want.vel_y_out);
            compare_field("pos_x_out", rsp_payload.pos_x_out, want.pos_x_out);
            compare_field("pos_y_out", rsp_payload.pos_y_out, want.pos_y_out);
            compare_field("angle_out", rsp_payload.angle_out, want.angle_out);
            compare_field("color_out", rsp_payload.color_out, want.color_out);
            compare_field("alpha_out", 32'(rsp_payload.alpha_out), 32'(want.alpha_out));
            compare_field("size_out", rsp_payload.size_out, want.size_out);
         end
      end
   end

   // safety net against a hung pipeline
   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // receiver back-pressure: a pattern picked at random from four styles,
   // overridden by a long hold-off when one is asked for
   // ---------------------------------------------------------------
   int stall_style = 0;
   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_style <= $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ((cycles % 5) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // offer one request and wait for it to be taken; valid stays high
   // inside a burst and drops for a random gap between bursts when gap_max is above 0
   task automatic send_particle(psu_pkg::req_type r);
      int gap;
      req_payload <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         if (gap_max > 0) begin
            gap = $urandom_range(1, gap_max);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering and let every outstanding record come back
   task automatic drain_pipeline();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (updated_records.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(psu_pkg::csr_idx_type idx, logic [31:0] value);
      drain_pipeline();
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         psu_pkg::CSR_START_COLOR: regs.start_color = value;
         psu_pkg::CSR_END_COLOR:   regs.end_color = value;
         psu_pkg::CSR_START_ALPHA: regs.start_alpha = value[16:0];
         psu_pkg::CSR_END_ALPHA:   regs.end_alpha = value[16:0];
         psu_pkg::CSR_EFFECT_MODE: regs.effect_mode = value[1:0];
         psu_pkg::CSR_SHRINK_END:  regs.shrink_end_scale = value[23:0];
         psu_pkg::CSR_GRAVITY_X:   regs.gravity_x = value;
         psu_pkg::CSR_GRAVITY_Y:   regs.gravity_y = value;
         default: ;
      endcase
   endtask

   task automatic load_regs(logic [31:0] sc, logic [31:0] ec, logic [31:0] sa,
                            logic [31:0] ea, logic [31:0] mode, logic [31:0] shrink,
                            logic [31:0] gx, logic [31:0] gy);
      write_reg(psu_pkg::CSR_START_COLOR, sc);
      write_reg(psu_pkg::CSR_END_COLOR, ec);
      write_reg(psu_pkg::CSR_START_ALPHA, sa);
      write_reg(psu_pkg::CSR_END_ALPHA, ea);
      write_reg(psu_pkg::CSR_EFFECT_MODE, mode);
      write_reg(psu_pkg::CSR_SHRINK_END, shrink);
      write_reg(psu_pkg::CSR_GRAVITY_X, gx);
      write_reg(psu_pkg::CSR_GRAVITY_Y, gy);
   endtask

   // random word leaning on the corners now and then
   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4: return 32'($urandom_range(0, 32'h0003_ffff));
         default: return $urandom();
      endcase
   endfunction

   // signed q16.16 value, mostly moderate so that few results saturate
   function automatic logic [31:0] moderate_word();
      if ($urandom_range(0, 5) == 0) return any_word();
      return 32'($signed(20'($urandom())));
   endfunction

   function automatic psu_pkg::req_type random_particle();
      psu_pkg::req_type r;
      logic [31:0] life;
      r.alive_in = ($urandom_range(0, 9) != 0);
      r.time_step = ($urandom_range(0, 7) == 0) ? any_word() : 32'($urandom_range(0, 8192));
      r.vel_x_in = moderate_word();
      r.vel_y_in = moderate_word();
      r.pos_x_in = moderate_word();
      r.pos_y_in = moderate_word();
      r.angle_in = moderate_word();
      r.spin_rate = moderate_word();
      r.base_size = any_word();
      case ($urandom_range(0, 5))
         0: begin
            // arbitrary record, often dying or saturating
            r.lifetime = any_word();
            r.age_in = any_word();
         end
         1: begin
            // near end of life
            life = $urandom_range(1000, 32'hffff_fff0);
            r.lifetime = life;
            r.age_in = life - 32'($urandom_range(0, 16384));
         end
         default: begin
            // living particle somewhere in its life
            life = $urandom();
            if (life < 32'd16) life = 32'd16;
            r.lifetime = life;
            r.age_in = 32'($urandom_range(0, life - 1)) >> $urandom_range(0, 3);
         end
      endcase
      return r;
   endfunction

   function automatic psu_pkg::req_type living(logic [31:0] age, logic [31:0] life,
                                               logic [31:0] dt);
      psu_pkg::req_type r;
      r = '{1'b1, age, life, 32'h0001_0000, -32'sh0000_8000, 32'h0010_0000,
            -32'sh0020_0000, 32'h0000_4000, 32'h0003_0000, 32'h0002_0000, dt};
      return r;
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   task automatic test_reset_defaults();
      psu_pkg::req_type r;
      // defaults: no fade, no shrink, white colour, no gravity
      send_particle(living(32'h0000_0000, 32'h0004_0000, 32'h0000_4000));
      send_particle(living(32'h0001_0000, 32'h0004_0000, 32'h0000_0000));
      // dead slot passes through with all-ones contents
      r = '1;
      r.alive_in = 1'b0;
      send_particle(r);
      drain_pipeline();
   endtask

   task automatic test_directed_cases();
      psu_pkg::req_type r;
      load_regs(32'h00ff_10f0, 32'hff00_f00f, 32'd65536, 32'd0, 32'd3, 32'h00_8000,
                32'hfff6_0000, 32'h0009_8000);
      // dies exactly at its lifetime, and one tick past it
      send_particle(living(32'h0001_0000, 32'h0002_0000, 32'h0001_0000));
      send_particle(living(32'h0001_0000, 32'h0002_0000, 32'h0001_0001));
      // zero lifetime dies at once
      send_particle(living(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
      // age saturates at the top and the particle dies
      send_particle(living(32'hffff_0000, 32'hffff_ffff, 32'hffff_ffff));
      // largest lifetime, age just below it so t is at its top
      send_particle(living(32'hffff_fffd, 32'hffff_ffff, 32'h0000_0001));
      // start of life, t is zero
      send_particle(living(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000));
      // position and velocity saturate both ways
      r = living(32'h0, 32'hffff_ffff, 32'hffff_ffff);
      r.vel_x_in = 32'sh7fff_ffff;
      r.vel_y_in = -32'sh8000_0000;
      r.pos_x_in = 32'sh7fff_0000;
      r.pos_y_in = -32'sh7fff_0000;
      r.spin_rate = -32'sh8000_0000;
      r.angle_in = -32'sh8000_0000;
      r.base_size = 32'hffff_ffff;
      send_particle(r);
      r.vel_x_in = -32'sh8000_0000;
      r.vel_y_in = 32'sh7fff_ffff;
      r.spin_rate = 32'sh7fff_ffff;
      r.angle_in = 32'sh7fff_ffff;
      send_particle(r);
      // dead input with the other fields at zero
      r = '0;
      send_particle(r);
      // size grows past its base with a large end scale
      load_regs(32'h0000_0000, 32'hffff_ffff, 32'h1ffff, 32'h1ffff, 32'd2, 32'hff_ffff,
                32'h7fff_ffff, 32'h8000_0000);
      send_particle(living(32'h0008_0000, 32'h0010_0000, 32'h0000_8000));
      r = living(32'h000f_0000, 32'h0010_0000, 32'h0000_0001);
      r.base_size = 32'hffff_ffff;
      send_particle(r);
      // fade only, alpha falls toward zero
      load_regs(32'hffff_ffff, 32'h0000_0000, 32'd65536, 32'd0, 32'd1, 32'd0,
                32'h0000_0000, 32'h0000_0000);
      send_particle(living(32'h0000_0000, 32'h0001_0000, 32'h0000_8000));
      send_particle(living(32'h0000_0000, 32'h0001_0000, 32'h0000_ffff));
      drain_pipeline();
   endtask

   task automatic test_random_phase(int count);
      load_regs($urandom(), $urandom(), $urandom_range(0, 65536), $urandom_range(0, 65536),
                $urandom_range(0, 3), $urandom_range(0, 24'hff_ffff),
                moderate_word(), moderate_word());
      for (int i = 0; i < count; i++) send_particle(random_particle());
      drain_pipeline();
   endtask

   // receiver holds off while the sender keeps offering, so the pipeline
   // fills and the input has to stall
   task automatic test_output_backpressure();
      gap_max = 0;
      hold_left = 300;
      for (int i = 0; i < 80; i++) send_particle(random_particle());
      gap_max = 6;
      drain_pipeline();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_output_backpressure();
      // extremes of every register, then random settings
      load_regs(32'h0000_0000, 32'h0000_0000, 32'd0, 32'd0, 32'd0, 32'd0,
                32'h8000_0000, 32'h8000_0000);
      for (int i = 0; i < 60; i++) send_particle(random_particle());
      load_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      for (int i = 0; i < 60; i++) send_particle(random_particle());
      repeat (5) test_random_phase(140);
      drain_pipeline();
      repeat (Latency + 10) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
